// File: rtl/core/lidar_scan_range_filter_macros.svh
// ----------------------------------------------------------------------------
// Lidar scan range filter - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_RANGE_FILTER_MACROS_SVH
`define LIDAR_SCAN_RANGE_FILTER_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define LSRF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its trigger
`define LSRF_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its trigger
`define LSRF_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lsrf_pkg.sv
// ----------------------------------------------------------------------------
// Lidar scan range filter - package
// Field widths, register indexes, fixed limits and the intensity compressor.
// ----------------------------------------------------------------------------
package lsrf_pkg;

    // Field and register widths
    localparam int RANGE_W     = 16;
    localparam int INTEN_W     = 16;
    localparam int INTEN_OUT_W = 8;
    localparam int CFG_ANGLE_W = 22;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_W     = 12;
    // Angle accumulator covers the full sample count range with margin
    localparam int ANGLE_W     = 26;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEN_EN   = 3'd4;

    // Register reset values
    localparam logic signed [CFG_ANGLE_W-1:0] MIN_ANGLE_RST = -22'sd1350000;
    localparam logic signed [CFG_ANGLE_W-1:0] MAX_ANGLE_RST = 22'sd1350000;
    localparam logic [RANGE_W-1:0]            RANGE_MIN_RST = 16'd10;
    localparam logic [RANGE_W-1:0]            RANGE_MAX_RST = 16'd20000;

    // Angle walk in 1e-4 degree
    localparam logic signed [ANGLE_W-1:0] START_ANGLE = -26'sd1350000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_STEP  = 26'sd3333;

    // Mask bands on the absolute angle
    localparam logic [ANGLE_W-1:0] POST_LO  = 26'd850000;
    localparam logic [ANGLE_W-1:0] POST_HI  = 26'd950000;
    localparam logic [ANGLE_W-1:0] REAR_LIM = 26'd1050000;
    localparam logic [ANGLE_W-1:0] MOUNT_LO = 26'd1100000;
    localparam logic [ANGLE_W-1:0] MOUNT_HI = 26'd1300000;
    localparam logic [RANGE_W-1:0] MOUNT_RANGE = 16'd1200;
    localparam logic [RANGE_W-1:0] UNIT_RANGE  = 16'd1;

    // Intensity compression
    localparam logic [INTEN_W-1:0] INTEN_CLIP     = 16'd55000;
    localparam logic [INTEN_W-1:0] INTEN_CLIP_VAL = 16'd600;
    localparam logic [INTEN_W-1:0] INTEN_KNEE     = 16'd5000;
    localparam logic [INTEN_OUT_W-1:0] INTEN_BASE = 8'd200;
    // floor(x/25) = (x * 5243) >> 17 for x <= 5000
    localparam logic [12:0] RECIP_25   = 13'd5243;
    localparam int          SHIFT_25   = 17;
    // floor(x/1200) = (x * 55925) >> 26 for x <= 50000
    localparam logic [15:0] RECIP_1200 = 16'd55925;
    localparam int          SHIFT_1200 = 26;

    typedef enum logic [1:0] {
        RC_INF  = 2'd0,
        RC_KEEP = 2'd1,
        RC_MASK = 2'd2
    } range_code_t;

    // Compress a raw intensity to its 8-bit code
    function automatic logic [INTEN_OUT_W-1:0] compress_intensity(
        input logic [INTEN_W-1:0] raw
    );
        logic [INTEN_W-1:0] clip;
        logic [INTEN_W-1:0] excess;
        logic [31:0]        prod_hi;
        logic [25:0]        prod_lo;
        logic [INTEN_OUT_W-1:0] res;
        clip    = (raw > INTEN_CLIP) ? INTEN_CLIP_VAL : raw;
        excess  = clip - INTEN_KNEE;
        prod_hi = excess * RECIP_1200;
        prod_lo = clip[12:0] * RECIP_25;
        if (clip > INTEN_KNEE)
        begin
            res = INTEN_BASE + INTEN_OUT_W'(prod_hi[31:SHIFT_1200]);
        end
        else
        begin
            res = prod_lo[SHIFT_25+7:SHIFT_25];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/lidar_scan_range_filter.sv
// ----------------------------------------------------------------------------
// Lidar scan range filter - top level
// Window, range coding, intensity compression and scan fault check per sample.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------
//  sample in | in        | in_valid / in_stall    | range_mm, raw_intensity,
//            |           |                        | last_sample
//  result    | out       | out_valid / out_stall  | in_window, range_out_mm,
//            |           |                        | range_code, intensity_out,
//            |           |                        | scan_end, scan_error
//  config    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle unless stalled; its result follows in the next cycle.
// The single result register sets the rate: it refills in the same cycle
// it is drained, so in_stall is high only while a result waits under out_stall.
// Reset clears the scan state and loads the register defaults; no clearing pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "lidar_scan_range_filter_macros.svh"

module lidar_scan_range_filter
    import lsrf_pkg::*;
#(
    parameter int MAX_SAMPLES = 2048
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [RANGE_W-1:0]     range_mm,
    input  logic [INTEN_W-1:0]     raw_intensity,
    input  logic                   last_sample,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   in_window,
    output logic [RANGE_W-1:0]     range_out_mm,
    output logic [1:0]             range_code,
    output logic [INTEN_OUT_W-1:0] intensity_out,
    output logic                   scan_end,
    output logic                   scan_error,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

    // Configuration registers
    logic signed [CFG_ANGLE_W-1:0] min_angle_reg;
    logic signed [CFG_ANGLE_W-1:0] max_angle_reg;
    logic [RANGE_W-1:0]            range_min_reg;
    logic [RANGE_W-1:0]            range_max_reg;
    logic                          inten_en_reg;

    // Scan state
    logic [IDX_W-1:0]          sample_index_reg, sample_index_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic [COUNT_W-1:0]        win_cnt_reg, win_cnt_next;
    logic [COUNT_W-1:0]        unit_cnt_reg, unit_cnt_next;
    logic [COUNT_W-1:0]        oor_cnt_reg, oor_cnt_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic                   in_window_reg;
    logic [RANGE_W-1:0]     range_out_reg;
    range_code_t            range_code_reg;
    logic [INTEN_OUT_W-1:0] intensity_reg;
    logic                   scan_end_reg;
    logic                   scan_error_reg;

    // Per-sample results
    logic                   accept;
    logic signed [ANGLE_W-1:0] min_ext;
    logic signed [ANGLE_W-1:0] max_ext;
    logic                   win;
    logic [ANGLE_W-1:0]     abs_angle;
    logic                   range_ok;
    logic                   mask;
    logic [RANGE_W-1:0]     rout;
    range_code_t            code;
    logic [INTEN_OUT_W-1:0] iout;
    logic                   err;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_angle_reg <= MIN_ANGLE_RST;
            max_angle_reg <= MAX_ANGLE_RST;
            range_min_reg <= RANGE_MIN_RST;
            range_max_reg <= RANGE_MAX_RST;
            inten_en_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_ANGLE: min_angle_reg <= cfg_data[CFG_ANGLE_W-1:0];
                CFG_MAX_ANGLE: max_angle_reg <= cfg_data[CFG_ANGLE_W-1:0];
                CFG_RANGE_MIN: range_min_reg <= cfg_data[RANGE_W-1:0];
                CFG_RANGE_MAX: range_max_reg <= cfg_data[RANGE_W-1:0];
                CFG_INTEN_EN:  inten_en_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Window test against neighbor angles
    assign min_ext = {{(ANGLE_W-CFG_ANGLE_W){min_angle_reg[CFG_ANGLE_W-1]}}, min_angle_reg};
    assign max_ext = {{(ANGLE_W-CFG_ANGLE_W){max_angle_reg[CFG_ANGLE_W-1]}}, max_angle_reg};
    assign win     = (angle_reg + ANGLE_STEP >= min_ext) && (angle_reg - ANGLE_STEP <= max_ext);

    // Range code and mask bands
    assign abs_angle = angle_reg[ANGLE_W-1] ? ANGLE_W'(-angle_reg) : ANGLE_W'(angle_reg);
    assign range_ok  = (range_mm > range_min_reg) && (range_mm < range_max_reg);
    assign mask      = ((abs_angle > POST_LO) && (abs_angle < POST_HI))
                    || (abs_angle > REAR_LIM)
                    || ((abs_angle > MOUNT_LO) && (abs_angle < MOUNT_HI)
                        && (range_mm < MOUNT_RANGE));

    always_comb
    begin
        rout = '0;
        code = RC_INF;
        iout = '0;
        if (win && range_ok)
        begin
            rout = range_mm;
            code = mask ? RC_MASK : RC_KEEP;
        end
        if (win && inten_en_reg)
        begin
            iout = compress_intensity(raw_intensity);
        end
    end

    // Advance counters and the sample walk
    always_comb
    begin
        win_cnt_next      = win_cnt_reg;
        unit_cnt_next     = unit_cnt_reg;
        oor_cnt_next      = oor_cnt_reg;
        sample_index_next = sample_index_reg;
        angle_next        = angle_reg;
        if (win)
        begin
            if (!(&win_cnt_reg))
            begin
                win_cnt_next = win_cnt_reg + 1'b1;
            end
            if ((range_mm == UNIT_RANGE) && !(&unit_cnt_reg))
            begin
                unit_cnt_next = unit_cnt_reg + 1'b1;
            end
            if (!range_ok && !(&oor_cnt_reg))
            begin
                oor_cnt_next = oor_cnt_reg + 1'b1;
            end
        end
        err = last_sample && ((win_cnt_next == '0) || (unit_cnt_next == win_cnt_next)
                              || (oor_cnt_next == win_cnt_next));
        if (last_sample)
        begin
            win_cnt_next      = '0;
            unit_cnt_next     = '0;
            oor_cnt_next      = '0;
            sample_index_next = '0;
            angle_next        = START_ANGLE;
        end
        else if (sample_index_reg < IDX_LAST)
        begin
            sample_index_next = sample_index_reg + 1'b1;
            angle_next        = angle_reg + ANGLE_STEP;
        end
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            angle_reg        <= START_ANGLE;
            win_cnt_reg      <= '0;
            unit_cnt_reg     <= '0;
            oor_cnt_reg      <= '0;
        end
        else if (accept)
        begin
            sample_index_reg <= sample_index_next;
            angle_reg        <= angle_next;
            win_cnt_reg      <= win_cnt_next;
            unit_cnt_reg     <= unit_cnt_next;
            oor_cnt_reg      <= oor_cnt_next;
        end
    end

    // Result valid: load on accept, drop when taken
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_window_reg  <= win;
            range_out_reg  <= rout;
            range_code_reg <= code;
            intensity_reg  <= iout;
            scan_end_reg   <= last_sample;
            scan_error_reg <= err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign in_window     = in_window_reg;
    assign range_out_mm  = range_out_reg;
    assign range_code    = range_code_reg;
    assign intensity_out = intensity_reg;
    assign scan_end      = scan_end_reg;
    assign scan_error    = scan_error_reg;

    // Assertions
    `LSRF_ASSERT_SAME(a_outside_blank, out_valid && !in_window, (range_code == RC_INF) && (range_out_mm == '0) && (intensity_out == '0), "sample outside window carries data")
    `LSRF_ASSERT_SAME(a_err_on_end, out_valid && scan_error, scan_end, "scan error flagged before scan end")
    `LSRF_ASSERT_NEXT(a_restart, accept && last_sample, (sample_index_reg == '0) && (angle_reg == START_ANGLE) && (win_cnt_reg == '0), "scan state not restarted after last sample")
    `LSRF_ASSERT_ALWAYS(a_count_order, (unit_cnt_reg <= win_cnt_reg) && (oor_cnt_reg <= win_cnt_reg), "fault counter exceeds window count")

endmodule
